[src/slcg_pkg.sv]
// slcg_pkg: constants, modular reduction helper and microcode table for the
// shuffled lcg random generator. No dependencies; imported by every module
// of the block and by its checker.
package slcg_pkg;

  // stream widths
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned OUT_DW  = 64;

  // lehmer generator constants
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam int unsigned PROD_W   = 46;

  // micro-program counter codes
  localparam logic [2:0] U_IDLE  = 3'd0;
  localparam logic [2:0] U_RMUL  = 3'd1;
  localparam logic [2:0] U_RFOLD = 3'd2;
  localparam logic [2:0] U_MUL   = 3'd3;
  localparam logic [2:0] U_FOLD  = 3'd4;
  localparam logic [2:0] U_SWAP  = 3'd5;

  // sequencer branch kinds
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_DISPATCH,
    BR_LOOP,
    BR_HOLD
  } br_e;

  // one control word per micro step
  typedef struct packed {
    logic       ready;     // take a beat from the input stream
    logic       mul_seed;  // multiply the incoming seed on a plain draw
    logic       mul_en;    // multiply the held value
    logic       fold_en;   // reduce the product into the held value
    logic       fill_en;   // write table entry during reseeding
    logic       idx_en;    // latch the table pick index
    logic       rd_en;     // read the picked table entry
    logic       swap_en;   // write back, load result register
    br_e        br;
    logic [2:0] target;
  } uword_t;

  // reduce lo + hi modulo 2^31-1, valid while the sum stays below 2*(2^31-1)
  function automatic logic [30:0] mod_red(input logic [30:0] lo, input logic [15:0] hi);
    logic [31:0] s;
    s = 32'(lo) + 32'(hi);
    if (s >= 32'(LCG_MOD)) begin
      s = s - 32'(LCG_MOD);
    end
    return s[30:0];
  endfunction

  // micro-program
  function automatic uword_t ucode_rom(input logic [2:0] upc);
    uword_t w;
    w = '{ready: 1'b0, mul_seed: 1'b0, mul_en: 1'b0, fold_en: 1'b0, fill_en: 1'b0,
          idx_en: 1'b0, rd_en: 1'b0, swap_en: 1'b0, br: BR_NEXT, target: U_IDLE};
    case (upc)
      U_IDLE: begin
        w.ready    = 1'b1;
        w.mul_seed = 1'b1;
        w.idx_en   = 1'b1;
        w.br       = BR_DISPATCH;
        w.target   = U_RMUL;
      end
      U_RMUL: begin
        w.mul_en = 1'b1;
      end
      U_RFOLD: begin
        w.fold_en = 1'b1;
        w.fill_en = 1'b1;
        w.br      = BR_LOOP;
        w.target  = U_RMUL;
      end
      U_MUL: begin
        w.mul_en = 1'b1;
        w.idx_en = 1'b1;
      end
      U_FOLD: begin
        w.fold_en = 1'b1;
        w.rd_en   = 1'b1;
      end
      U_SWAP: begin
        w.swap_en = 1'b1;
        w.br      = BR_HOLD;
        w.target  = U_IDLE;
      end
      default: begin
        w.br     = BR_HOLD;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[src/slcg_lehmer.sv]
// slcg_lehmer: one lehmer step x*16807 mod 2^31-1 in two parts: input
// reduction and multiply into a product register, then a fold.
// Depends on slcg_pkg.
module slcg_lehmer import slcg_pkg::*; (
  input  logic              clk_i,
  input  logic              mul_en_i,
  input  logic [SEED_W-1:0] x_i,
  output logic [VAL_W-1:0]  fold_o
);

  logic [VAL_W-1:0]  x_red;
  logic [PROD_W-1:0] prod_q;

  // bring the operand (up to 2^31) below the modulus
  assign x_red = mod_red(x_i[30:0], 16'(x_i[31]));

  // 31 x 15 multiply
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= PROD_W'(x_red) * PROD_W'(LCG_MULT);
    end
  end

  // 2^31 == 1 mod m, so fold the high part onto the low part
  assign fold_o = mod_red(prod_q[30:0], 16'(prod_q[45:31]));

endmodule

[src/shuffled_lcg_random_generator_unit.sv]
// shuffled_lcg_random_generator_unit: minimal standard lehmer generator with a
// shuffle table, run by a microcoded sequencer. Depends on slcg_pkg, slcg_lehmer.
//
//  channel   dir  tdata (low bit up)                 meaning
//  s_axis    in   [31:0] seed_in (signed)            caller seed, <= 0 reseeds
//  m_axis    out  [30:0] sample, [61:31] seed_out    shuffled value, new seed
//
// a plain draw steps through accept, fold and table read, then swap into result reg.
// a reseeding draw first runs TableSize+WarmupSteps lehmer steps: every
// lehmer step uses the one shared multiplier and then its fold.
// one item is in work at a time; the input is taken again while a result waits.
// a stalled output holds the sequencer in its swap step until the beat is taken.
// reset clears the kept output, so the first beat always reseeds the table.
module shuffled_lcg_random_generator_unit import slcg_pkg::*; #(
  parameter int unsigned TableSize   = 32,
  parameter int unsigned WarmupSteps = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SEED_W-1:0] s_axis_tdata,   // [31:0] seed_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata    // [30:0] sample, [61:31] seed_out
);

  localparam int unsigned IW      = $clog2(TableSize);
  localparam int unsigned CW      = $clog2(TableSize + WarmupSteps);
  localparam longint      PickDiv = 1 + (64'd2147483646 / TableSize);

  uword_t            uw;
  logic [2:0]        upc_q, upc_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SEED_W-1:0] x_q;
  logic [VAL_W-1:0]  last_q;
  logic [IW-1:0]     idx_q, idx_sel;
  logic [VAL_W-1:0]  rd_q;
  logic [VAL_W-1:0]  fold;
  logic              out_valid_q;
  logic [VAL_W-1:0]  sample_q, seed_out_q;
  logic              in_beat, reseed, out_free, cnt_in_tbl;
  logic              mul_en;
  logic [SEED_W-1:0] mul_x;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  tbl_q [TableSize];

  assign uw = ucode_rom(upc_q);

  // handshake and decisions
  assign s_axis_tready = uw.ready;
  assign in_beat       = s_axis_tvalid & uw.ready;
  assign reseed        = s_axis_tdata[31] | (s_axis_tdata == '0) | (last_q == '0);
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign cnt_in_tbl    = 32'(cnt_q) < 32'(TableSize);

  // shared lehmer unit
  assign mul_en = uw.mul_en | (uw.mul_seed & in_beat & ~reseed);
  assign mul_x  = uw.mul_seed ? s_axis_tdata : x_q;

  slcg_lehmer u_lehmer (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .x_i      (mul_x),
    .fold_o   (fold)
  );

  // table pick: count the bucket bounds at or below the kept output
  always_comb begin
    idx_sel = '0;
    for (int k = 1; k < TableSize; k++) begin
      if (64'(last_q) >= 64'(k) * 64'(PickDiv)) begin
        idx_sel = IW'(k);
      end
    end
  end

  // sequencer
  always_comb begin
    upc_d = upc_q + 3'd1;
    cnt_d = cnt_q;
    case (uw.br)
      BR_NEXT: begin
        upc_d = upc_q + 3'd1;
      end
      BR_DISPATCH: begin
        if (!in_beat) begin
          upc_d = upc_q;
        end else if (reseed) begin
          upc_d = uw.target;
          cnt_d = CW'(TableSize + WarmupSteps - 1);
        end else begin
          upc_d = U_FOLD;
        end
      end
      BR_LOOP: begin
        if (cnt_q != '0) begin
          upc_d = uw.target;
          cnt_d = cnt_q - CW'(1);
        end
      end
      BR_HOLD: begin
        upc_d = out_free ? uw.target : upc_q;
      end
      default: begin
        upc_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  // working value: start value on reseed, lehmer result after each fold
  always_ff @(posedge clk_i) begin
    if (uw.ready && in_beat && reseed) begin
      x_q <= s_axis_tdata[31] ? (~s_axis_tdata + SEED_W'(1)) : SEED_W'(1);
    end else if (uw.fold_en) begin
      x_q <= SEED_W'(fold);
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.idx_en) begin
      idx_q <= idx_sel;
    end
  end

  // kept output: last reseed step, then the swapped-out entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (uw.fill_en && cnt_q == '0) begin
      last_q <= fold;
    end else if (uw.swap_en && out_free) begin
      last_q <= rd_q;
    end
  end

  // shuffle table memory
  assign wr_en   = (uw.fill_en & cnt_in_tbl) | (uw.swap_en & out_free);
  assign wr_addr = uw.swap_en ? idx_q : cnt_q[IW-1:0];
  assign wr_data = uw.swap_en ? x_q[VAL_W-1:0] : fold;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[wr_addr] <= wr_data;
    end
    if (uw.rd_en) begin
      rd_q <= tbl_q[idx_q];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.swap_en && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.swap_en && out_free) begin
      sample_q   <= rd_q;
      seed_out_q <= x_q[VAL_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, seed_out_q, sample_q};

endmodule

[src/slcg_checker.sv]
// slcg_checker: port-level checks for the shuffled lcg generator, bound to
// the top level. Depends on slcg_pkg.
module slcg_checker import slcg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [SEED_W-1:0] s_axis_tdata,   // [31:0] seed_in
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata    // [30:0] sample, [61:31] seed_out
);

  logic in_beat;
  assign in_beat = s_axis_tvalid & s_axis_tready;

  // a waiting seed beat holds until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("seed beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one item in work: input closes right after a beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  // a result does not appear right after an input beat
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid))
    else $error("result appeared too soon after an input beat");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind shuffled_lcg_random_generator_unit slcg_checker u_slcg_checker (.*);

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for shuffled_lcg_random_generator_unit, driving seed beats
// and comparing each sample/seed pair against a behavioral lehmer + shuffle predictor.
// Depends on slcg_pkg and the generator unit.
`timescale 1ns / 100ps

module tb_top;
  import slcg_pkg::*;

  localparam int unsigned TABLE_SIZE   = 32;
  localparam int unsigned WARMUP_STEPS = 8;
  localparam logic [31:0] PICK_DIV     = 32'd1 + (32'(LCG_MOD) - 32'd1) / TABLE_SIZE;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_DRAWS = 1400;

  typedef struct packed {
    logic [VAL_W-1:0] sample;
    logic [VAL_W-1:0] seed_out;
  } draw_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SEED_W-1:0] s_axis_tdata = '0;   // [31:0] seed_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;        // [30:0] sample, [61:31] seed_out

  // predictor state
  logic [VAL_W-1:0] kept_out;
  logic [VAL_W-1:0] pick_table [TABLE_SIZE];
  logic [VAL_W-1:0] last_seed_out;

  draw_t       pending_draws[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_stall = 0;
  logic        quiet_stretch = 1'b0;

  shuffled_lcg_random_generator_unit #(
    .TableSize  (TABLE_SIZE),
    .WarmupSteps(WARMUP_STEPS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one lehmer step, x may be up to 2^31
  function automatic logic [VAL_W-1:0] lehmer_next(input logic [31:0] x);
    logic [63:0] prod;
    prod = (64'(x) % 64'(LCG_MOD)) * 64'(LCG_MULT);
    return VAL_W'(prod % 64'(LCG_MOD));
  endfunction

  // expected sample and seed for one accepted seed beat, updates shuffle state
  function automatic draw_t predict_draw(input logic [31:0] seed);
    logic [31:0] x;
    logic [31:0] idx;
    draw_t       d;
    if (seed[31] || seed == 32'd0 || kept_out == '0) begin
      // reseed: warm up, then fill the table from the last steps, entry 0 last
      x = seed[31] ? -seed : 32'd1;
      for (int j = TABLE_SIZE + WARMUP_STEPS - 1; j >= 0; j--) begin
        x = {1'b0, lehmer_next(x)};
        if (j < TABLE_SIZE) pick_table[j] = x[VAL_W-1:0];
      end
      kept_out = pick_table[0];
    end else begin
      x = seed;
    end
    x = {1'b0, lehmer_next(x)};
    idx = 32'(kept_out) / PICK_DIV;
    if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
    kept_out = pick_table[idx];
    pick_table[idx] = x[VAL_W-1:0];
    d.sample   = kept_out;
    d.seed_out = x[VAL_W-1:0];
    return d;
  endfunction

  // source gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one seed beat, predict its result once accepted
  task automatic send_seed(input logic [31:0] seed);
    int unsigned gap;
    draw_t       d;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seed;
    do @(posedge clk_i); while (!s_axis_tready);
    d = predict_draw(seed);
    last_seed_out = d.seed_out;
    pending_draws.push_back(d);
  endtask

  // first beat after reset always reseeds, even with a positive seed
  task automatic test_first_draw();
    send_seed(32'd12345);
    send_seed({1'b0, last_seed_out});
    send_seed({1'b0, last_seed_out});
  endtask

  // field extremes and the negative and zero seed reseed triggers
  task automatic test_seed_extremes();
    send_seed(32'd1);
    send_seed(32'h8000_0000);   // most negative, magnitude 2^31
    send_seed(32'hFFFF_FFFF);   // -1
    send_seed(32'h8000_0001);   // most negative in range
    send_seed(32'd0);           // zero seed
    send_seed(32'd2147483646);
    send_seed({1'b0, last_seed_out});
    send_seed(32'hFFFF_FFFE);
    send_seed(32'h5555_5555);
    send_seed(32'h2AAA_AAAA);
  endtask

  // seed equal to the modulus gives a zero lehmer value stored in the table;
  // keep drawing with plain seeds so the zero entry can come back out
  task automatic test_zero_lehmer();
    send_seed(32'd2147483647);
    for (int i = 0; i < 10; i++) begin
      send_seed({1'b0, 31'($urandom_range(1, 32'h7FFF_FFFE))});
    end
  endtask

  // random stream: mostly seeds fed back as a caller would, plus noise
  task automatic test_feedback_stream();
    int unsigned r;
    logic [31:0] seed;
    for (int unsigned n = 0; n < RANDOM_DRAWS; n++) begin
      if (n % 100 == 0) quiet_stretch <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 72)      seed = {1'b0, last_seed_out};
      else if (r < 82) seed = {1'b0, 31'($urandom)};
      else if (r < 90) seed = {1'b1, 31'($urandom)};
      else if (r < 93) seed = 32'd0;
      else if (r < 96) seed = 32'd2147483647;
      else             seed = $urandom;
      send_seed(seed);
    end
    quiet_stretch <= 1'b0;
  endtask

  // result sink backpressure
  always @(posedge clk_i) begin
    if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= sink_stall - 1;
    end else if (rst_ni && !quiet_stretch && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                     : $urandom_range(9, 39);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    draw_t exp_d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result beat, tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_d = pending_draws.pop_front();
        if (m_axis_tdata[30:0] !== exp_d.sample) begin
          $display("%0t: sample mismatch: expected %0d, actual %0d",
                   $time, exp_d.sample, m_axis_tdata[30:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[61:31] !== exp_d.seed_out) begin
          $display("%0t: seed_out mismatch: expected %0d, actual %0d",
                   $time, exp_d.seed_out, m_axis_tdata[61:31]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat accepted for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    kept_out = '0;
    last_seed_out = '0;
    for (int i = 0; i < TABLE_SIZE; i++) pick_table[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_draw();
    test_seed_extremes();
    test_zero_lehmer();
    test_feedback_stream();
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then watch for stray beats
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/slcg_pkg.sv
src/slcg_lehmer.sv
src/shuffled_lcg_random_generator_unit.sv
src/slcg_checker.sv
tb/sv/tb_top.sv
